// ===== rtl/kms_pkg.sv =====
// Shared types, register codes and bit-level helpers for the k-mer mismatch search.
// Used by kms_cell, kmer_mismatch_search_top and the testbench; no dependencies.
`default_nettype none

package kms_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int NUM_BASES  = 32;
    localparam int CODE_W     = 2 * NUM_BASES;

    // configuration register indexes
    localparam logic [1:0] REG_MISMATCH_LIMIT = 2'd0;
    localparam logic [1:0] REG_KMER_LENGTH    = 2'd1;
    localparam logic [1:0] REG_ACTIVE_QUERIES = 2'd2;
    localparam logic [1:0] REG_USE_REVERSE    = 2'd3;

    // input item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // one position of the result chain
    typedef struct packed {
        logic       hit;
        logic [4:0] slot;
        logic       rev;
        logic [5:0] count;
    } t_stage;

    // control broadcast to every cell
    typedef struct packed {
        logic       load;
        logic       start;
        logic       shift;
        logic [4:0] entry;
        logic [5:0] active;
        logic       use_rev;
        logic [5:0] limit;
    } t_cell_ctl;

    // mismatching bases: fold each symbol pair of the XOR, then a popcount tree
    function automatic logic [5:0] base_diffs(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
        logic [CODE_W-1:0] d;
        logic [31:0]       x;
        int                i;
        d = a ^ b;
        for (i = 0; i < 32; i++) begin
            x[i] = d[2*i] | d[2*i+1];
        end
        x = (x & 32'h5555_5555) + ((x >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x & 32'h0f0f_0f0f) + ((x >> 4) & 32'h0f0f_0f0f);
        x = x + (x >> 8);
        x = x + (x >> 16);
        return x[5:0];
    endfunction

    // reverse complement over len bases; zero length gives zero
    function automatic logic [CODE_W-1:0] rev_comp(input logic [CODE_W-1:0] code,
                                                   input logic [5:0] len);
        logic [5:0]        lenc;
        logic [5:0]        src;
        logic [CODE_W-1:0] sh;
        logic [CODE_W-1:0] r;
        int                p;
        lenc = (len > 6'(NUM_BASES)) ? 6'(NUM_BASES) : len;
        r    = '0;
        for (p = 0; p < NUM_BASES; p++) begin
            src = lenc - 6'(p) - 6'd1;
            sh  = code >> {src[4:0], 1'b0};
            if (6'(p) < lenc) begin
                r[2*p +: 2] = sh[1:0] ^ 2'b11;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kms_cell.sv =====
// One cell of the compare chain: holds one query slot (forward and reverse
// complement) and two result stages that shift towards cell 0. Uses kms_pkg.
`default_nettype none

module kms_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [4:0]                    i_slot,
    input  wire kms_pkg::t_cell_ctl            i_ctl,
    input  wire logic [kms_pkg::CODE_W-1:0]    i_code,
    input  wire logic [kms_pkg::CODE_W-1:0]    i_rev_code,
    input  wire kms_pkg::t_stage               i_fwd_next,
    input  wire kms_pkg::t_stage               i_rev_next,
    output kms_pkg::t_stage                    o_fwd,
    output kms_pkg::t_stage                    o_rev
);

    logic [kms_pkg::CODE_W-1:0] r_fwd_code;
    logic [kms_pkg::CODE_W-1:0] r_rev_code;
    kms_pkg::t_stage            r_fwd;
    kms_pkg::t_stage            r_rev;
    logic [5:0]                 fwd_cnt;
    logic [5:0]                 rev_cnt;
    logic                       in_use;

    // query storage, written by a load item addressed to this slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.entry == i_slot)) begin
            r_fwd_code <= i_code;
            r_rev_code <= i_rev_code;
        end
    end

    // compare against the target on the broadcast bus
    always_comb begin
        fwd_cnt = kms_pkg::base_diffs(i_code, r_fwd_code);
        rev_cnt = kms_pkg::base_diffs(i_code, r_rev_code);
        in_use  = {1'b0, i_slot} < i_ctl.active;
    end

    // result stages: capture on a search, otherwise hand along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= '0;
            r_rev <= '0;
        end else if (i_ctl.start) begin
            r_fwd.hit   <= in_use && (fwd_cnt <= i_ctl.limit);
            r_fwd.slot  <= i_slot;
            r_fwd.rev   <= 1'b0;
            r_fwd.count <= fwd_cnt;
            r_rev.hit   <= in_use && i_ctl.use_rev && (rev_cnt <= i_ctl.limit);
            r_rev.slot  <= i_slot;
            r_rev.rev   <= 1'b1;
            r_rev.count <= rev_cnt;
        end else if (i_ctl.shift) begin
            r_fwd <= i_fwd_next;
            r_rev <= i_rev_next;
        end
    end

    assign o_fwd = r_fwd;
    assign o_rev = r_rev;

endmodule

`default_nettype wire

// ===== rtl/kmer_mismatch_search_top.sv =====
// Top level of the k-mer mismatch search: configuration registers, a row of
// kms_cell compare cells and the result output register. Uses kms_pkg, kms_cell.
//
// Usage:
//   Input stream s_*: a load item (tuser kind = 0) writes one query slot and its
//   reverse complement. A search item (kind = 1) compares the target code with
//   every active slot in parallel in the cycle it is accepted. The hits then leave
//   the cell row one chain position per cycle while m_tready does not hold it,
//   forward slots 0..31 first, then reverse slots 0..31; the search ends as soon
//   as no hit remains in the chain, and a search with no hit leaves s_tready high.
//   A hit at the head of the chain moves into the output register on a shift.
//   s_tready is high whenever no hit is left in the chain; a new item is taken
//   while the final result still waits in the output register.
//   Output stream m_*: one item per match, tlast on the final match.
//   When m_tready is low the chain holds at a hit until the register frees.
//   The user writes configuration (i_cfg_*) only while no search is in progress;
//   the block itself does not enforce this. Reset (synchronous, active low)
//   loads the register defaults and empties the chain and the output register;
//   query slots are undefined until loaded.
`default_nettype none

module kmer_mismatch_search_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config: 0 mismatch_limit, 1 kmer_length, 2 active_queries, 3 use_reverse
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [5:0]   i_cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [4:0] entry_index, [68:5] code, [100:69] target_id, [132:101] target_start
    input  wire logic [135:0] s_tdata,
    // [0] kind
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [4:0] query_slot, [10:5] mismatch_count, [42:11] match_target_id,
    // [74:43] match_start
    output logic [79:0]       m_tdata,
    // [0] reverse_strand
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int N = kms_pkg::NUM_SLOTS;

    logic [5:0]  r_limit;
    logic [5:0]  r_klen;
    logic [5:0]  r_active;
    logic        r_use_rev;
    logic [31:0] r_tid;
    logic [31:0] r_tstart;
    logic        r_out_valid;
    logic [4:0]  r_out_slot;
    logic        r_out_rev;
    logic [5:0]  r_out_count;
    logic [31:0] r_out_tid;
    logic [31:0] r_out_start;
    logic        r_out_last;

    logic                       in_acc;
    logic [4:0]                 in_entry;
    logic [kms_pkg::CODE_W-1:0] in_code;
    logic [kms_pkg::CODE_W-1:0] in_rev_code;
    kms_pkg::t_cell_ctl         ctl;
    kms_pkg::t_stage            fwd_st [N];
    kms_pkg::t_stage            rev_st [N];
    kms_pkg::t_stage            head;
    logic                       rest_hit;
    logic                       busy;
    logic                       shift;
    logic                       emit;

    // input unpacking
    assign in_acc      = s_tvalid && s_tready;
    assign in_entry    = s_tdata[4:0];
    assign in_code     = s_tdata[68:5];
    assign in_rev_code = kms_pkg::rev_comp(in_code, r_klen);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= 6'd5;
            r_klen    <= 6'd19;
            r_active  <= 6'd0;
            r_use_rev <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kms_pkg::REG_MISMATCH_LIMIT: r_limit   <= i_cfg_data;
                kms_pkg::REG_KMER_LENGTH:    r_klen    <= i_cfg_data;
                kms_pkg::REG_ACTIVE_QUERIES: r_active  <= i_cfg_data;
                kms_pkg::REG_USE_REVERSE:    r_use_rev <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // chain status
    assign head = fwd_st[0];
    always_comb begin
        rest_hit = 1'b0;
        for (int k = 0; k < N; k++) begin
            if (k > 0) begin
                rest_hit = rest_hit | fwd_st[k].hit;
            end
            rest_hit = rest_hit | rev_st[k].hit;
        end
    end
    assign busy     = rest_hit | head.hit;
    assign s_tready = !busy;
    assign shift    = !head.hit || !r_out_valid || m_tready;
    assign emit     = head.hit && shift;

    // broadcast control to the cells
    always_comb begin
        ctl.load    = in_acc && (s_tuser == kms_pkg::KIND_LOAD);
        ctl.start   = in_acc && (s_tuser == kms_pkg::KIND_SEARCH);
        ctl.shift   = shift;
        ctl.entry   = in_entry;
        ctl.active  = (r_active > 6'(N)) ? 6'(N) : r_active;
        ctl.use_rev = r_use_rev;
        ctl.limit   = r_limit;
    end

    // row of cells; the reverse stages feed into the forward stages at the end
    for (genvar k = 0; k < N; k++) begin : g_cell
        kms_pkg::t_stage fwd_next;
        kms_pkg::t_stage rev_next;
        if (k == N - 1) begin : g_end
            assign fwd_next = rev_st[0];
            assign rev_next = '0;
        end else begin : g_mid
            assign fwd_next = fwd_st[k+1];
            assign rev_next = rev_st[k+1];
        end
        kms_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_slot     (5'(k)),
            .i_ctl      (ctl),
            .i_code     (in_code),
            .i_rev_code (in_rev_code),
            .i_fwd_next (fwd_next),
            .i_rev_next (rev_next),
            .o_fwd      (fwd_st[k]),
            .o_rev      (rev_st[k])
        );
    end

    // target fields of the search in progress
    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_tid    <= s_tdata[100:69];
            r_tstart <= s_tdata[132:101];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_slot  <= head.slot;
            r_out_rev   <= head.rev;
            r_out_count <= head.count;
            r_out_tid   <= r_tid;
            r_out_start <= r_tstart;
            r_out_last  <= !rest_hit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out_start, r_out_tid, r_out_count, r_out_slot};
    assign m_tuser  = r_out_rev;
    assign m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== verif/tb_kmer_mismatch_search_top.sv =====
// Self-checking testbench for kmer_mismatch_search_top: query table loads, searches
// and register settings, each result checked against a behavioural table model.
// Depends on rtl/kms_pkg.sv, rtl/kms_cell.sv and rtl/kmer_mismatch_search_top.sv.
`timescale 1ns / 100ps

module tb_kmer_mismatch_search_top;
    import kms_pkg::*;

    localparam int SETTLE_CYCLES  = 70;    // margin for the longest search to drain
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake or register write

    // one input item
    typedef struct packed {
        logic        kind;
        logic [4:0]  entry;
        logic [63:0] code;
        logic [31:0] tid;
        logic [31:0] tstart;
    } t_item;

    // one reported match
    typedef struct packed {
        logic [4:0]  slot;
        logic        rev;
        logic [5:0]  count;
        logic [31:0] tid;
        logic [31:0] tstart;
        logic        last;
    } t_match;

    logic         i_clk;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_we    = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [5:0]   i_cfg_data  = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata     = '0;
    logic         s_tuser     = 1'b0;
    logic         m_tvalid;
    logic         m_tready    = 1'b1;
    logic [79:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    // table model and its register copies
    logic [63:0] fwd_tab [NUM_SLOTS];
    logic [63:0] rev_tab [NUM_SLOTS];
    logic [5:0]  cfg_limit    = 6'd5;
    logic [5:0]  cfg_kmer_len = 6'd19;
    logic [5:0]  cfg_active   = 6'd0;
    logic        cfg_use_rev  = 1'b1;

    t_match pending_matches[$];

    int  n_errors    = 0;
    int  n_checked   = 0;
    int  n_loads     = 0;
    int  n_searches  = 0;
    int  n_settings  = 0;
    int  max_hits    = 0;
    int  burst_left  = 0;
    bit  gaps_on     = 1'b0;
    int  rx_mode     = 0;
    int  rx_phase    = 0;
    int  quiet_count = 0;

    kmer_mismatch_search_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    // bases that differ: a symbol counts once whichever of its bits differ
    function automatic logic [5:0] mismatch_bases(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        logic [5:0]  n;
        int          i;
        d = a ^ b;
        n = '0;
        for (i = 0; i < 32; i++) begin
            n = n + 6'(d[2*i] | d[2*i+1]);
        end
        return n;
    endfunction

    // reversed and complemented over len bases, len clipped to the table width
    function automatic logic [63:0] rev_complement(input logic [63:0] code,
                                                   input logic [5:0] len);
        logic [63:0] r;
        int          lc;
        int          i;
        lc = (len > NUM_BASES) ? NUM_BASES : int'(len);
        r  = '0;
        for (i = 0; i < lc; i++) begin
            r[2*(lc-1-i) +: 2] = code[2*i +: 2] ^ 2'b11;
        end
        return r;
    endfunction

    // bases over which k-mers are generated and mutated
    function automatic int kmer_span();
        int lc;
        lc = (cfg_kmer_len > NUM_BASES) ? NUM_BASES : int'(cfg_kmer_len);
        return (lc == 0) ? NUM_BASES : lc;
    endfunction

    function automatic logic [63:0] random_kmer(input bit well_formed);
        logic [63:0] code;
        int          span;
        span = kmer_span();
        code = {$urandom, $urandom};
        if (well_formed && span < 32) begin
            code = code & ((64'd1 << (2 * span)) - 64'd1);
        end
        return code;
    endfunction

    // substitute n random bases within the k-mer
    function automatic logic [63:0] mutate_bases(input logic [63:0] code, input int n);
        logic [63:0] r;
        int          i;
        int          p;
        r = code;
        for (i = 0; i < n; i++) begin
            p = $urandom_range(0, kmer_span() - 1);
            r[2*p +: 2] = r[2*p +: 2] ^ 2'($urandom_range(1, 3));
        end
        return r;
    endfunction

    // update the table on a load, queue the expected matches on a search
    task automatic predict_item(input t_item it);
        t_match      hits [64];
        t_match      m;
        int          cnt;
        int          n;
        int          pass;
        int          j;
        logic [63:0] q;
        logic [5:0]  mm;
        if (it.kind == KIND_LOAD) begin
            fwd_tab[it.entry] = it.code;
            rev_tab[it.entry] = rev_complement(it.code, cfg_kmer_len);
            n_loads++;
        end else begin
            n_searches++;
            cnt = 0;
            n   = (cfg_active > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_active);
            for (pass = 0; pass < 2; pass++) begin
                if (pass == 0 || cfg_use_rev) begin
                    for (j = 0; j < n; j++) begin
                        q  = (pass == 1) ? rev_tab[j] : fwd_tab[j];
                        mm = mismatch_bases(it.code, q);
                        if (mm <= cfg_limit) begin
                            m.slot   = 5'(j);
                            m.rev    = (pass == 1);
                            m.count  = mm;
                            m.tid    = it.tid;
                            m.tstart = it.tstart;
                            m.last   = 1'b0;
                            hits[cnt] = m;
                            cnt++;
                        end
                    end
                end
            end
            for (j = 0; j < cnt; j++) begin
                m      = hits[j];
                m.last = (j == cnt - 1);
                pending_matches.push_back(m);
            end
            if (cnt > max_hits) max_hits = cnt;
        end
    endtask

    // ------------------------------------------------------------ drivers

    // all tasks below start and end just after a falling edge
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if (gaps_on) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.tstart, it.tid, it.code, it.entry};
        do @(posedge i_clk); while (!s_tready);
        predict_item(it);
        @(negedge i_clk);
    endtask

    function automatic t_item make_item(input logic kind, input logic [4:0] entry,
                                        input logic [63:0] code, input logic [31:0] tid,
                                        input logic [31:0] tstart);
        t_item it;
        it.kind   = kind;
        it.entry  = entry;
        it.code   = code;
        it.tid    = tid;
        it.tstart = tstart;
        return it;
    endfunction

    // stop sending, wait for every expected match, then let the block settle
    task automatic drain_matches();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [5:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        case (idx)
            REG_MISMATCH_LIMIT: cfg_limit    = data;
            REG_KMER_LENGTH:    cfg_kmer_len = data;
            REG_ACTIVE_QUERIES: cfg_active   = data;
            REG_USE_REVERSE:    cfg_use_rev  = data[0];
            default: ;
        endcase
    endtask

    // writes the registers only once the block has drained
    task automatic set_config(input logic [5:0] limit, input logic [5:0] len,
                              input logic [5:0] active, input logic [5:0] rev_data);
        drain_matches();
        cfg_write(REG_MISMATCH_LIMIT, limit);
        cfg_write(REG_KMER_LENGTH, len);
        cfg_write(REG_ACTIVE_QUERIES, active);
        cfg_write(REG_USE_REVERSE, rev_data);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // mostly near-copies of stored queries, some loads and random targets
    task automatic run_search_phase(input int items);
        t_item       it;
        int          k;
        int          r;
        int          n;
        int          j;
        int          lim;
        logic [63:0] base;
        for (k = 0; k < items; k++) begin
            n   = (cfg_active > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_active);
            lim = (cfg_limit > 32) ? 32 : int'(cfg_limit);
            r   = $urandom_range(0, 99);
            it  = make_item(KIND_SEARCH, 5'($urandom_range(0, 31)), '0, $urandom, $urandom);
            if (r < 12) begin
                it.kind = KIND_LOAD;
                it.code = random_kmer($urandom_range(0, 3) != 0);
            end else if (r < 24 || n == 0) begin
                it.code = {$urandom, $urandom};
            end else begin
                j = $urandom_range(0, n - 1);
                if (cfg_use_rev && $urandom_range(0, 1) == 1) base = rev_tab[j];
                else base = fwd_tab[j];
                it.code = mutate_bases(base, $urandom_range(0, lim + 2));
            end
            send_item(it);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // default registers: no query active, so searches report nothing
    task automatic test_reset_defaults();
        send_item(make_item(KIND_LOAD, 5'd0, 64'd0, 32'd0, 32'd0));
        send_item(make_item(KIND_LOAD, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom));
        send_item(make_item(KIND_LOAD, 5'd2, random_kmer(1'b1), $urandom, $urandom));
        // bits above the k-mer are kept in the forward entry
        send_item(make_item(KIND_LOAD, 5'd3, {$urandom, $urandom}, $urandom, $urandom));
        send_item(make_item(KIND_SEARCH, 5'd31, fwd_tab[2], $urandom, $urandom));
    endtask

    task automatic test_exact_and_reverse();
        set_config(6'd5, 6'd19, 6'd4, 6'd1);
        send_item(make_item(KIND_SEARCH, 5'd0, fwd_tab[2], 32'hFFFF_FFFF, 32'd0));
        send_item(make_item(KIND_SEARCH, 5'd0, rev_tab[2], 32'd0, 32'hFFFF_FFFF));
        send_item(make_item(KIND_SEARCH, 5'd31, 64'd0, $urandom, $urandom));
        send_item(make_item(KIND_SEARCH, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, $urandom));
    endtask

    task automatic test_limit_zero_forward_only();
        set_config(6'd0, 6'd19, 6'd4, 6'd0);
        send_item(make_item(KIND_SEARCH, 5'd3, fwd_tab[3], $urandom, $urandom));
        send_item(make_item(KIND_SEARCH, 5'd3, rev_tab[2], $urandom, $urandom));
    endtask

    // zero, oversize, full and single-base lengths, then report-all limits
    task automatic test_length_extremes();
        set_config(6'd63, 6'd0, 6'd4, 6'd1);
        send_item(make_item(KIND_LOAD, 5'd4, {$urandom, $urandom}, $urandom, $urandom));
        set_config(6'd63, 6'd45, 6'd4, 6'd1);
        send_item(make_item(KIND_LOAD, 5'd5, {$urandom, $urandom}, $urandom, $urandom));
        set_config(6'd63, 6'd32, 6'd4, 6'd1);
        send_item(make_item(KIND_LOAD, 5'd6, {$urandom, $urandom}, $urandom, $urandom));
        set_config(6'd63, 6'd1, 6'd4, 6'd1);
        send_item(make_item(KIND_LOAD, 5'd7, random_kmer(1'b1), $urandom, $urandom));
        set_config(6'd63, 6'd1, 6'd8, 6'd1);
        send_item(make_item(KIND_SEARCH, 5'd0, {$urandom, $urandom}, $urandom, $urandom));
        set_config(6'd32, 6'd1, 6'd8, 6'd1);
        send_item(make_item(KIND_SEARCH, 5'd0, fwd_tab[7], $urandom, $urandom));
    endtask

    // every slot written before any wider active range is used
    task automatic test_table_fill();
        int k;
        set_config(6'd6, 6'd24, 6'd8, 6'd1);
        gaps_on = 1'b1;
        rx_mode = 1;
        for (k = 0; k < NUM_SLOTS; k++) begin
            send_item(make_item(KIND_LOAD, 5'(k), random_kmer($urandom_range(0, 3) != 0),
                                $urandom, $urandom));
        end
    endtask

    task automatic test_back_to_back();
        set_config(6'd5, 6'd19, 6'd32, 6'd1);
        gaps_on = 1'b0;
        rx_mode = 0;
        run_search_phase(60);
    endtask

    task automatic test_exact_forward_full_length();
        set_config(6'd0, 6'd32, 6'd17, 6'd0);
        gaps_on = 1'b1;
        rx_mode = 1;
        run_search_phase(50);
    endtask

    task automatic test_single_base();
        set_config(6'd3, 6'd1, 6'd32, 6'd1);
        gaps_on = 1'b1;
        rx_mode = 2;
        run_search_phase(50);
    endtask

    // every compare reported: up to 64 matches per search
    task automatic test_report_all();
        set_config(6'd40, 6'd12, 6'd63, 6'd1);
        gaps_on = 1'b1;
        rx_mode = 1;
        run_search_phase(10);
        set_config(6'd32, 6'd0, 6'd32, 6'd1);
        rx_mode = 0;
        run_search_phase(10);
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < 3; p++) begin
            // upper data bits of the reverse flag are don't-care
            set_config(6'($urandom_range(0, 8)), 6'($urandom_range(0, 40)),
                       6'($urandom_range(1, 32)), 6'($urandom_range(0, 63)));
            gaps_on = ($urandom_range(0, 1) == 1);
            rx_mode = $urandom_range(0, 2);
            run_search_phase(40);
        end
    endtask

    // ------------------------------------------------------------ receiver

    always @(negedge i_clk) begin
        rx_phase++;
        case (rx_mode)
            1:       m_tready <= ($urandom_range(0, 99) >= 35);
            2:       m_tready <= ((rx_phase % 5) >= 2);
            default: m_tready <= 1'b1;
        endcase
    end

    // compare each accepted match with the oldest expectation
    always @(posedge i_clk) begin : match_check
        t_match got;
        t_match want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.slot   = m_tdata[4:0];
            got.count  = m_tdata[10:5];
            got.tid    = m_tdata[42:11];
            got.tstart = m_tdata[74:43];
            got.rev    = m_tuser;
            got.last   = m_tlast;
            if (pending_matches.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected match: slot %0d rev %0d count %0d id %h start %h",
                             got.slot, got.rev, got.count, got.tid, got.tstart);
            end else begin
                want = pending_matches.pop_front();
                n_checked++;
                if (got.slot !== want.slot || got.rev !== want.rev ||
                    got.count !== want.count || got.tid !== want.tid ||
                    got.tstart !== want.tstart || got.last !== want.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("match %0d wrong:", n_checked);
                        $display("  exp slot %0d rev %0d count %0d id %h start %h last %0d",
                                 want.slot, want.rev, want.count, want.tid,
                                 want.tstart, want.last);
                        $display("  got slot %0d rev %0d count %0d id %h start %h last %0d",
                                 got.slot, got.rev, got.count, got.tid, got.tstart, got.last);
                    end
                end
            end
        end
    end

    // watchdog: too long without any handshake or register write
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // ---------------------------------------------------------- sequence

    initial begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            fwd_tab[k] = '0;
            rev_tab[k] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_exact_and_reverse();
        test_limit_zero_forward_only();
        test_length_extremes();
        test_table_fill();
        test_back_to_back();
        test_exact_forward_full_length();
        test_single_base();
        test_report_all();
        test_random_settings();
        drain_matches();

        $display("covered %0d loads and %0d searches over %0d register settings",
                 n_loads, n_searches, n_settings);
        $display("checked %0d matches, up to %0d from one search, %0d errors",
                 n_checked, max_hits, n_errors);
        if (n_errors == 0 && pending_matches.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
